### hdl/sampled_lru_page_victim_select_core_assert.svh
// Assertion macros for the sampled LRU victim select core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SAMPLED_LRU_PAGE_VICTIM_SELECT_CORE_ASSERT_SVH
`define SAMPLED_LRU_PAGE_VICTIM_SELECT_CORE_ASSERT_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define SLVS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slvs assertion failed");

// ante holds in a cycle -> cons holds in the next cycle
`define SLVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slvs assertion failed");

`endif

### hdl/slvs_pkg.sv
// Shared types and constants for the sampled LRU victim select core.
// No dependencies.
`default_nettype none

package slvs_pkg;

    localparam int PAGES      = 16;
    localparam int PAGE_BYTES = 4096;

    localparam int MASK_BITS  = 16;
    localparam int PIDX_W     = 4;
    localparam int ADDR_W     = 32;
    localparam int TICK_W     = 32;
    localparam int IDX_W      = $clog2(PAGES);
    localparam int CNT_W      = $clog2(PAGES + 1);
    localparam int CMP_W      = (CNT_W > PIDX_W) ? CNT_W : PIDX_W;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    localparam int PADDR_W = 2;
    localparam logic [PADDR_W-1:0] REG_BASE_ADDRESS = 2'd0;

    typedef enum logic [1:0] {
        CMD_SET_OCC = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_VICTIM  = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture request fields
        logic tick_step;   // step one page; stamp it if occupied and accessed
        logic scan_step;   // read one stamp
        logic form;        // build victim result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;        // page counter at final page
    } dp_stat_t;

endpackage

`default_nettype wire

### hdl/slvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module slvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/slvs_ctrl.sv
// Sequencer for the sampled LRU victim select core.
// Depends on slvs_pkg.
`default_nettype none

module slvs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         command,
    input  wire slvs_pkg::dp_stat_t stat,
    output slvs_pkg::dp_cmd_t       cmd,
    output logic                    busy,
    output logic                    done
);

    import slvs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TICK  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_FORM  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (cmd_t'(command))
                        CMD_TICK:   state_next = S_TICK;
                        CMD_VICTIM: state_next = S_SCAN;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_TICK:
            begin
                cmd.tick_step = 1'b1;
                if (stat.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last stamp is compared in the datapath here
                state_next = S_FORM;
            end
            S_FORM:
            begin
                cmd.form   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

`default_nettype wire

### hdl/slvs_dp.sv
// Datapath: occupancy flags, tick counter, stamp RAM, oldest-stamp scan.
// Depends on slvs_pkg and slvs_ram.
`default_nettype none

module slvs_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire slvs_pkg::dp_cmd_t             cmd,
    output slvs_pkg::dp_stat_t                 stat,
    input  wire logic [1:0]                    command,
    input  wire logic [slvs_pkg::PIDX_W-1:0]   page_index,
    input  wire logic                          occupied,
    input  wire logic [slvs_pkg::MASK_BITS-1:0] accessed_mask,
    input  wire logic [slvs_pkg::ADDR_W-1:0]   base_address,
    output logic      [slvs_pkg::ADDR_W-1:0]   victim_address,
    output logic                               victim_found,
    output logic      [slvs_pkg::MASK_BITS-1:0] cleared_mask
);

    import slvs_pkg::*;

    logic [PAGES-1:0]     occ_reg;
    logic [PAGES-1:0]     stamp_valid_reg;
    logic [TICK_W-1:0]    tick_count_reg;
    logic [PAGES-1:0]     stamp_mask_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 rd_pend_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [TICK_W-1:0]    best_time_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic                 any_reg;
    logic [ADDR_W-1:0]    victim_address_reg;
    logic                 victim_found_reg;
    logic [MASK_BITS-1:0] cleared_mask_reg;

    logic [PAGES-1:0]     acc_ext;
    logic [PAGES-1:0]     stamp_mask_next;
    logic [TICK_W-1:0]    ram_rdata;
    logic [TICK_W-1:0]    stamp;
    logic                 ram_we;
    logic                 take;
    logic                 occ_write;

    assign acc_ext         = PAGES'(accessed_mask);
    assign stamp_mask_next = occ_reg & acc_ext;

    assign ram_we = cmd.tick_step && stamp_mask_reg[idx_reg];

    slvs_ram #(
        .WIDTH (TICK_W),
        .DEPTH (PAGES)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (tick_count_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // never-stamped pages read as tick zero
    assign stamp = stamp_valid_reg[rd_idx_reg] ? ram_rdata : '0;
    assign take  = rd_pend_reg && occ_reg[rd_idx_reg] &&
                   (!any_reg || (stamp < best_time_reg));

    assign occ_write = cmd.load && (cmd_t'(command) == CMD_SET_OCC) &&
                       (CMP_W'(page_index) < CMP_W'(PAGES));

    assign stat.last = (idx_reg == IDX_W'(PAGES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg         <= '0;
            stamp_valid_reg <= '0;
            tick_count_reg  <= '0;
            idx_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            any_reg         <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.scan_step;
            if (occ_write)
            begin
                occ_reg[IDX_W'(page_index)] <= occupied;
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
                any_reg <= 1'b0;
                if ((cmd_t'(command) == CMD_TICK) && (tick_count_reg != TICK_MAX))
                begin
                    tick_count_reg <= tick_count_reg + 1'b1;
                end
            end
            else if (cmd.tick_step || cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (ram_we)
            begin
                stamp_valid_reg[idx_reg] <= 1'b1;
            end
            if (take)
            begin
                any_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            stamp_mask_reg     <= stamp_mask_next;
            victim_address_reg <= '0;
            victim_found_reg   <= 1'b0;
            cleared_mask_reg   <= (cmd_t'(command) == CMD_TICK) ?
                                  MASK_BITS'(stamp_mask_next) : '0;
            best_idx_reg       <= '0;
        end
        if (cmd.scan_step)
        begin
            rd_idx_reg <= idx_reg;
        end
        if (take)
        begin
            best_time_reg <= stamp;
            best_idx_reg  <= rd_idx_reg;
        end
        if (cmd.form)
        begin
            victim_address_reg <= base_address +
                                  ADDR_W'(32'(best_idx_reg) * 32'(PAGE_BYTES));
            victim_found_reg   <= any_reg;
        end
    end

    assign victim_address = victim_address_reg;
    assign victim_found   = victim_found_reg;
    assign cleared_mask   = cleared_mask_reg;

endmodule

`default_nettype wire

### hdl/sampled_lru_page_victim_select_core.sv
// Top level of the sampled LRU page victim select core: config register,
// controller and datapath. Depends on slvs_pkg, slvs_ctrl, slvs_dp.
//
//  port group   direction  handshake
//  request      in         start, busy (taken when start && !busy)
//  result       out        done strobe, one cycle, no backpressure
//  config       in/out     APB: psel, penable, pwrite, paddr, pwdata, prdata
//
// Latency below counts from the accepting edge to the edge that takes the result.
// Set occupancy and the unused command: 1 cycle, done comes right after accept.
// Tick steps through every page: one stamp RAM write per occupied page in accessed_mask.
// Victim query: one stamp RAM read per page, then compare and
// address build. busy stays high through the done cycle, so a new request is taken only after done.
// Reset clears occupancy, stamp valid bits and the tick counter at once.
`default_nettype none
`include "sampled_lru_page_victim_select_core_assert.svh"

module sampled_lru_page_victim_select_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [slvs_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    input  wire logic                           start,
    output logic                                busy,
    output logic                                done,
    input  wire logic [1:0]                     command,
    input  wire logic [slvs_pkg::PIDX_W-1:0]    page_index,
    input  wire logic                           occupied,
    input  wire logic [slvs_pkg::MASK_BITS-1:0] accessed_mask,
    output logic      [slvs_pkg::ADDR_W-1:0]    victim_address,
    output logic                                victim_found,
    output logic      [slvs_pkg::MASK_BITS-1:0] cleared_mask
);

    import slvs_pkg::*;

    logic [ADDR_W-1:0] base_address_reg;
    dp_cmd_t           dp_cmd;
    dp_stat_t          dp_stat;
    logic              start_req;
    logic [3:0]        dp_steps;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == REG_BASE_ADDRESS))
        begin
            base_address_reg <= pwdata;
        end
    end

    assign prdata = (paddr == REG_BASE_ADDRESS) ? base_address_reg : '0;

    assign start_req = start && !busy;

    slvs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_req),
        .command (command),
        .stat    (dp_stat),
        .cmd     (dp_cmd),
        .busy    (busy),
        .done    (done)
    );

    slvs_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (dp_cmd),
        .stat           (dp_stat),
        .command        (command),
        .page_index     (page_index),
        .occupied       (occupied),
        .accessed_mask  (accessed_mask),
        .base_address   (base_address_reg),
        .victim_address (victim_address),
        .victim_found   (victim_found),
        .cleared_mask   (cleared_mask)
    );

    assign dp_steps = {dp_cmd.load, dp_cmd.tick_step, dp_cmd.scan_step, dp_cmd.form};

    `SLVS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `SLVS_ASSERT_NEXT(a_done_idle, done, !busy)
    `SLVS_ASSERT_SAME(a_load_on_accept, dp_cmd.load, start && !busy)
    `SLVS_ASSERT_SAME(a_steps_exclusive, 1'b1, $onehot0(dp_steps))

endmodule

`default_nettype wire
